// ===== hdl/lmd_pkg.sv =====
// Shared widths, register indexes and result-slot codes for the 2D local maximum detector.
// Depends on nothing; imported by the top level.
`default_nettype none

package lmd_pkg;

  // Fixed port field widths
  localparam int VALUE_W    = 16;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int COUNT_W    = 22;
  localparam int WIDTH_RW   = 11;
  localparam int HEIGHT_RW  = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Bit positions of the pending-result mask, in emission order
  localparam int RES_MID   = 0;  // pixel one row up, same column
  localparam int RES_LEFT  = 1;  // last row, pixel one column left
  localparam int RES_FINAL = 2;  // last pixel of the image
  localparam int RES_N     = 3;

  // Border facts of the pixel held in the decision stage
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_col;
  } lmd_edge_t;

endpackage

`default_nettype wire

// ===== hdl/lmd_cell.sv =====
// One window cell: holds a middle-row and a current-row pixel and passes them on.
// No package dependencies; chained in the top level.
`default_nettype none

module lmd_cell #(
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              shift,
  input  logic [DATA_W-1:0] mid_in,
  input  logic [DATA_W-1:0] cur_in,
  output logic [DATA_W-1:0] mid,
  output logic [DATA_W-1:0] cur
);

  always_ff @(posedge clk) begin
    if (shift) begin
      mid <= mid_in;
      cur <= cur_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lmd_line_store.sv =====
// Three-row line store: one write port and two registered read ports.
// Rows sit in slots 0..2 of LINE_W entries each; no package dependencies.
`default_nettype none

module lmd_line_store #(
  parameter int LINE_W = 1024,
  parameter int DATA_W = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [1:0]                wslot,
  input  logic [$clog2(LINE_W)-1:0] wcol,
  input  logic [DATA_W-1:0]         wdata,
  input  logic                      re,
  input  logic [1:0]                aslot,
  input  logic [$clog2(LINE_W)-1:0] acol,
  input  logic [1:0]                bslot,
  input  logic [$clog2(LINE_W)-1:0] bcol,
  output logic [DATA_W-1:0]         rdata_a,
  output logic [DATA_W-1:0]         rdata_b
);

  localparam int CW    = $clog2(LINE_W);
  localparam int DEPTH = 3 * LINE_W;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] BASE1 = AW'(LINE_W);
  localparam logic [AW-1:0] BASE2 = AW'(2 * LINE_W);

  logic [DATA_W-1:0] mem [DEPTH];

  function automatic logic [AW-1:0] addr_of(input logic [1:0] slot, input logic [CW-1:0] c);
    logic [AW-1:0] base;
    case (slot)
      2'd1:    base = BASE1;
      2'd2:    base = BASE2;
      default: base = '0;
    endcase
    return base + AW'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_of(wslot, wcol)] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[addr_of(aslot, acol)];
      rdata_b <= mem[addr_of(bslot, bcol)];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/local_max_2d_detector_top.sv =====
// Streaming 2D four-neighbour local maximum detector, top level.
// Depends on lmd_pkg, lmd_line_store and lmd_cell.
//
// Usage:
//   Pixels enter in raster order on pixel_value with in_valid/in_stall; a
//   transaction happens when in_valid is high and in_stall is low. Results
//   leave on the decided_* / is_peak / peak_count / last fields with
//   out_valid/out_stall. Each pixel of row r decides the pixel above it; in
//   the last row each pixel also decides its left neighbour, and the final
//   pixel decides itself, whose result carries last.
//   The first result of a pixel is registered in the decision stage and
//   then in the output register.
//   Throughput: one pixel per cycle outside the last row while out_stall is
//   low; in the last row a pixel waits for each result it causes (two for
//   most pixels of a taller image, one in a single-row image, up to three
//   for the final pixel): the single output register takes one per cycle.
//   Config: cfg_write/cfg_index/cfg_data write image_width (0) or
//   image_height (1) while idle; a write restarts the image.
//   Reset: counters and peak count clear, width = min(1024, MAX_WIDTH),
//   height = 1. The line store needs no clearing; rows are read only after
//   they are written. When out_stall holds, the decision stage holds its
//   pixel and in_stall rises until the output register drains.
`default_nettype none

module local_max_2d_detector_top
  import lmd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VALUE_W-1:0]   pixel_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   decided_value,
  output logic [ROW_W-1:0]     decided_row,
  output logic [COL_W-1:0]     decided_col,
  output logic                 is_peak,
  output logic [COUNT_W-1:0]   peak_count,
  output logic                 last
);

  localparam int PB = (PIXEL_BITS < VALUE_W) ? PIXEL_BITS : VALUE_W;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // Configuration, held as last column / last row
  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic [31:0]   cfg_w_val;
  logic [31:0]   cfg_h_val;
  logic [CW-1:0] cfg_w_last;
  logic [RW-1:0] cfg_h_last;
  logic          cfg_hit;

  // Input side position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [1:0]    slot_cur;
  logic [1:0]    slot_prev;
  logic [1:0]    slot_prev2;
  logic          in_accept;
  logic          at_last_col;
  logic          at_last_row;
  logic [1:0]    rd_a_slot;
  logic [CW-1:0] rd_a_col;

  // Decision stage
  logic              s1_valid;
  logic [PB-1:0]     s1_pix;
  logic [RW-1:0]     s1_row;
  logic [CW-1:0]     s1_col;
  logic              s1_fwd;
  lmd_edge_t         s1_edge;
  logic [RES_N-1:0]  rem;
  logic [RES_N-1:0]  rem_next;
  logic [RES_N-1:0]  rem_init;
  logic [RES_N-1:0]  sel;
  logic              load_out;
  logic              s1_retire;

  logic [PB-1:0] rd_a;
  logic [PB-1:0] rd_b;
  logic [PB-1:0] mid_right;
  logic [PB-1:0] mid0;
  logic [PB-1:0] mid1;
  logic [PB-1:0] cur0;
  logic [PB-1:0] cur1;

  logic          peak_mid;
  logic          peak_left;
  logic          peak_final;
  logic [PB-1:0] sel_val;
  logic [RW-1:0] sel_row;
  logic [CW-1:0] sel_col;
  logic          sel_peak;
  logic          sel_final;

  logic [COUNT_W-1:0] peaks;
  logic [COUNT_W-1:0] peaks_next;

  // ---------------- configuration ----------------
  assign cfg_w_val = 32'(cfg_data[WIDTH_RW-1:0]);
  assign cfg_h_val = 32'(cfg_data[HEIGHT_RW-1:0]);

  always_comb begin
    if (cfg_w_val == 32'd0) begin
      cfg_w_last = '0;
    end else if (cfg_w_val > 32'(MAX_WIDTH)) begin
      cfg_w_last = CW'(MAX_WIDTH - 1);
    end else begin
      cfg_w_last = CW'(cfg_w_val - 32'd1);
    end
    if (cfg_h_val == 32'd0) begin
      cfg_h_last = '0;
    end else if (cfg_h_val > 32'(MAX_HEIGHT)) begin
      cfg_h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      cfg_h_last = RW'(cfg_h_val - 32'd1);
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = cfg_write;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  // ---------------- input side ----------------
  assign in_accept   = in_valid && !in_stall;
  assign at_last_col = (col == width_last);
  assign at_last_row = (row == height_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= CW'(WIDTH_RST - 1);
      height_last <= '0;
      col         <= '0;
      row         <= '0;
      slot_cur    <= 2'd0;
      slot_prev   <= 2'd2;
      slot_prev2  <= 2'd1;
    end else begin
      if (cfg_hit) begin
        col <= '0;
        row <= '0;
      end else if (in_accept) begin
        if (at_last_col) begin
          col        <= '0;
          row        <= at_last_row ? '0 : row + RW'(1);
          slot_cur   <= (slot_cur == 2'd2) ? 2'd0 : slot_cur + 2'd1;
          slot_prev  <= slot_cur;
          slot_prev2 <= slot_prev;
        end else begin
          col <= col + CW'(1);
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_last  <= cfg_w_last;
          REG_IMAGE_HEIGHT: height_last <= cfg_h_last;
          default: ;
        endcase
      end
    end
  end

  // Port A prefetches the middle-row pixel right of the one being decided;
  // at the end of a row it fetches column 0 of this row for the next row.
  assign rd_a_slot = at_last_col ? slot_cur : slot_prev;
  assign rd_a_col  = at_last_col ? '0 : col + CW'(1);

  lmd_line_store #(
    .LINE_W (MAX_WIDTH),
    .DATA_W (PB)
  ) u_line_store (
    .clk     (clk),
    .we      (in_accept),
    .wslot   (slot_cur),
    .wcol    (col),
    .wdata   (pixel_value[PB-1:0]),
    .re      (in_accept),
    .aslot   (rd_a_slot),
    .acol    (rd_a_col),
    .bslot   (slot_prev2),
    .bcol    (col),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // ---------------- decision stage ----------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix          <= pixel_value[PB-1:0];
      s1_row          <= row;
      s1_col          <= col;
      // single-column image: the prefetch hits the entry written this cycle
      s1_fwd          <= at_last_col && (col == '0);
      s1_edge.row_ge1 <= (row != '0);
      s1_edge.row_ge2 <= (row > RW'(1));
      s1_edge.col_ge1 <= (col != '0);
      s1_edge.col_ge2 <= (col > CW'(1));
      s1_edge.last_col <= at_last_col;
    end
  end

  assign mid_right = s1_fwd ? s1_pix : rd_a;

  // Window chain: cell 0 holds mid(c), cur(c-1); cell 1 holds mid(c-1), cur(c-2)
  lmd_cell #(.DATA_W (PB)) u_cell0 (
    .clk    (clk),
    .shift  (s1_retire),
    .mid_in (mid_right),
    .cur_in (s1_pix),
    .mid    (mid0),
    .cur    (cur0)
  );

  lmd_cell #(.DATA_W (PB)) u_cell1 (
    .clk    (clk),
    .shift  (s1_retire),
    .mid_in (mid0),
    .cur_in (cur0),
    .mid    (mid1),
    .cur    (cur1)
  );

  assign peak_mid   = (!s1_edge.row_ge2 || (mid0 > rd_b)) && (mid0 > s1_pix) &&
                      (!s1_edge.col_ge1 || (mid0 > mid1)) &&
                      (s1_edge.last_col || (mid0 > mid_right));
  assign peak_left  = (!s1_edge.row_ge1 || (cur0 > mid1)) &&
                      (!s1_edge.col_ge2 || (cur0 > cur1)) && (cur0 > s1_pix);
  assign peak_final = (!s1_edge.row_ge1 || (s1_pix > mid0)) &&
                      (!s1_edge.col_ge1 || (s1_pix > cur0));

  // Issue pending results lowest bit first
  always_comb begin
    sel       = '0;
    sel_val   = s1_pix;
    sel_row   = s1_row;
    sel_col   = s1_col;
    sel_peak  = peak_final;
    sel_final = 1'b0;
    if (rem[RES_MID]) begin
      sel[RES_MID] = 1'b1;
      sel_val      = mid0;
      sel_row      = s1_row - RW'(1);
      sel_peak     = peak_mid;
    end else if (rem[RES_LEFT]) begin
      sel[RES_LEFT] = 1'b1;
      sel_val       = cur0;
      sel_col       = s1_col - CW'(1);
      sel_peak      = peak_left;
    end else if (rem[RES_FINAL]) begin
      sel[RES_FINAL] = 1'b1;
      sel_final      = 1'b1;
    end
  end

  assign rem_init[RES_MID]   = (row != '0);
  assign rem_init[RES_LEFT]  = at_last_row && (col != '0);
  assign rem_init[RES_FINAL] = at_last_row && at_last_col;

  assign rem_next   = rem & ~sel;
  assign load_out   = s1_valid && (rem != '0) && (!out_valid || !out_stall);
  assign s1_retire  = s1_valid && ((rem == '0) || (load_out && (rem_next == '0)));
  assign in_stall   = s1_valid && !s1_retire;
  assign peaks_next = peaks + COUNT_W'(sel_peak);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rem      <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        rem      <= rem_init;
      end else begin
        if (s1_retire) begin
          s1_valid <= 1'b0;
        end
        if (load_out) begin
          rem <= rem_next;
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      peaks     <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        peaks <= '0;
      end else if (load_out) begin
        peaks <= sel_final ? '0 : peaks_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      decided_value <= VALUE_W'(sel_val);
      decided_row   <= ROW_W'(sel_row);
      decided_col   <= COL_W'(sel_col);
      is_peak       <= sel_peak;
      peak_count    <= peaks_next;
      last          <= sel_final;
    end
  end

  // ---------------- assertions ----------------
  a_rem_idle: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> (rem == '0))
    else $error("pending results with empty decision stage");

  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (load_out && sel_final) |=> (peaks == '0))
    else $error("peak count not restarted after final result");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (decided_col == COL_W'(width_last)) &&
                            (decided_row == ROW_W'(height_last)))
    else $error("last flag on a pixel that is not the final one");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_accept && at_last_col) |=> (col == '0))
    else $error("column counter did not wrap at row end");

endmodule

`default_nettype wire
